// ===== sv/rsess_pkg.sv =====
// shared types and constants for the replay session table
`default_nettype none

package rsess_pkg;

    localparam int NUM_SESSIONS_DEF = 8;

    localparam int ID_W   = 64;
    localparam int CTR_W  = 32;
    localparam int SLOT_W = 3;
    localparam int STAT_W = 2;

    // input beat layout of s_tdata
    localparam int IN_DATA_W  = 2 * ID_W + CTR_W;
    localparam int OUT_DATA_W = 8;

    typedef enum logic [STAT_W-1:0] {
        STATUS_OK      = 2'd0,
        STATUS_REPLAY  = 2'd1,
        STATUS_UNKNOWN = 2'd2
    } status_t;

    typedef enum logic {
        REQ_VERIFY = 1'b0,
        REQ_ADD    = 1'b1
    } req_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_DELIVER
    } state_t;

    typedef struct packed {
        logic [ID_W-1:0]  id_high;
        logic [ID_W-1:0]  id_low;
        logic [CTR_W-1:0] counter;
    } entry_t;

endpackage

`default_nettype wire

// ===== sv/replay_session_table.sv =====
// Replay session table: a recency-ordered table of 128-bit session IDs, each with the
// last accepted 32-bit counter, cleared at reset. A verify beat looks the ID up and
// reports accepted (counter stored, entry moved to the front), replay (counter not
// above the stored one) or unknown session. An add beat places the ID into the first
// empty slot, else the oldest slot past the two most recent with a zero counter, else
// the oldest slot, and moves it to the front with a zero counter. One compare unit
// looks at the head of the table while the table rotates through it, one entry per
// cycle; a beat then passes the update and deliver states before the next beat can
// be taken, and the deliver state registers the result once the output is free. The
// next request is taken while a finished result still waits on the output.
`default_nettype none

module replay_session_table #(
    parameter int NUM_SESSIONS = rsess_pkg::NUM_SESSIONS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // session_id_high [63:0], session_id_low [127:64], nonce_counter [159:128]
    input  wire logic [rsess_pkg::IN_DATA_W-1:0]  s_tdata,
    // req_type [0]
    input  wire logic                             s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // status [1:0], slot_found [4:2], zeros [7:5]
    output logic [rsess_pkg::OUT_DATA_W-1:0]      m_tdata
);

    localparam int IDX_W = $clog2(NUM_SESSIONS);
    localparam int SEXT_W = (IDX_W > rsess_pkg::SLOT_W) ? IDX_W : rsess_pkg::SLOT_W;
    localparam int ID_W = rsess_pkg::ID_W;
    localparam int CTR_W = rsess_pkg::CTR_W;

    rsess_pkg::state_t state_reg, state_next;
    rsess_pkg::entry_t table_reg [NUM_SESSIONS];
    rsess_pkg::entry_t table_next [NUM_SESSIONS];

    logic                req_reg, req_next;
    logic [ID_W-1:0]     hi_reg, hi_next;
    logic [ID_W-1:0]     lo_reg, lo_next;
    logic [CTR_W-1:0]    ctr_reg, ctr_next;

    logic [IDX_W-1:0]    scan_idx_reg, scan_idx_next;
    logic                match_found_reg, match_found_next;
    logic [IDX_W-1:0]    match_idx_reg, match_idx_next;
    logic                replay_reg, replay_next;
    logic                empty_found_reg, empty_found_next;
    logic [IDX_W-1:0]    empty_idx_reg, empty_idx_next;
    logic                zero_found_reg, zero_found_next;
    logic [IDX_W-1:0]    zero_idx_reg, zero_idx_next;

    rsess_pkg::status_t            res_status_reg, res_status_next;
    logic [rsess_pkg::SLOT_W-1:0]  res_slot_reg, res_slot_next;

    logic                               m_tvalid_reg, m_tvalid_next;
    logic [rsess_pkg::OUT_DATA_W-1:0]   m_tdata_reg, m_tdata_next;

    // shared compare unit on the head of the table
    rsess_pkg::entry_t head;
    logic              id_eq;
    logic              ctr_zero;
    logic              top_zero;
    logic              not_newer;

    // update selection
    logic              do_move;
    logic [IDX_W-1:0]  move_pos;
    logic [IDX_W-1:0]  rep_idx;
    logic [SEXT_W-1:0] rep_ext;
    rsess_pkg::entry_t new_entry;

    assign head      = table_reg[0];
    assign id_eq     = (head.id_high == hi_reg) && (head.id_low == lo_reg);
    assign ctr_zero  = (head.counter == '0);
    assign top_zero  = (head.id_high[ID_W-1:ID_W/2] == '0);
    assign not_newer = (ctr_reg <= head.counter);

    assign s_tready = (state_reg == rsess_pkg::ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= rsess_pkg::ST_IDLE;
            scan_idx_reg    <= '0;
            match_found_reg <= 1'b0;
            empty_found_reg <= 1'b0;
            zero_found_reg  <= 1'b0;
            m_tvalid_reg    <= 1'b0;
            for (int k = 0; k < NUM_SESSIONS; k++)
            begin
                table_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg       <= state_next;
            scan_idx_reg    <= scan_idx_next;
            match_found_reg <= match_found_next;
            empty_found_reg <= empty_found_next;
            zero_found_reg  <= zero_found_next;
            m_tvalid_reg    <= m_tvalid_next;
            for (int k = 0; k < NUM_SESSIONS; k++)
            begin
                table_reg[k] <= table_next[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        hi_reg         <= hi_next;
        lo_reg         <= lo_next;
        ctr_reg        <= ctr_next;
        match_idx_reg  <= match_idx_next;
        replay_reg     <= replay_next;
        empty_idx_reg  <= empty_idx_next;
        zero_idx_reg   <= zero_idx_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        m_tdata_reg    <= m_tdata_next;
    end

    // choice of slot and replacement entry for the update cycle
    always_comb
    begin
        do_move   = 1'b0;
        move_pos  = '0;
        rep_idx   = '0;
        new_entry = '{id_high: hi_reg, id_low: lo_reg, counter: ctr_reg};
        if (req_reg == rsess_pkg::REQ_ADD)
        begin
            do_move = 1'b1;
            // an add always leaves a zero counter in the chosen slot
            new_entry.counter = '0;
            if (empty_found_reg)
            begin
                move_pos = empty_idx_reg;
            end
            else if (zero_found_reg)
            begin
                move_pos = zero_idx_reg;
            end
            else
            begin
                move_pos = IDX_W'(NUM_SESSIONS - 1);
            end
            rep_idx = move_pos;
        end
        else if (match_found_reg)
        begin
            rep_idx  = match_idx_reg;
            do_move  = !replay_reg;
            move_pos = match_idx_reg;
        end
        rep_ext = SEXT_W'(rep_idx);
    end

    always_comb
    begin
        state_next       = state_reg;
        req_next         = req_reg;
        hi_next          = hi_reg;
        lo_next          = lo_reg;
        ctr_next         = ctr_reg;
        scan_idx_next    = scan_idx_reg;
        match_found_next = match_found_reg;
        match_idx_next   = match_idx_reg;
        replay_next      = replay_reg;
        empty_found_next = empty_found_reg;
        empty_idx_next   = empty_idx_reg;
        zero_found_next  = zero_found_reg;
        zero_idx_next    = zero_idx_reg;
        res_status_next  = res_status_reg;
        res_slot_next    = res_slot_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_tdata_next     = m_tdata_reg;
        for (int k = 0; k < NUM_SESSIONS; k++)
        begin
            table_next[k] = table_reg[k];
        end

        unique case (state_reg)
            rsess_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    req_next         = s_tuser;
                    hi_next          = s_tdata[ID_W-1:0];
                    lo_next          = s_tdata[2*ID_W-1:ID_W];
                    ctr_next         = s_tdata[2*ID_W+CTR_W-1:2*ID_W];
                    scan_idx_next    = '0;
                    match_found_next = 1'b0;
                    empty_found_next = 1'b0;
                    zero_found_next  = 1'b0;
                    state_next       = rsess_pkg::ST_SCAN;
                end
            end
            rsess_pkg::ST_SCAN:
            begin
                if (id_eq && !match_found_reg)
                begin
                    match_found_next = 1'b1;
                    match_idx_next   = scan_idx_reg;
                    replay_next      = not_newer;
                end
                if (top_zero && ctr_zero && !empty_found_reg)
                begin
                    empty_found_next = 1'b1;
                    empty_idx_next   = scan_idx_reg;
                end
                // the last zero counter seen from slot 2 upward is the oldest one
                if (ctr_zero && (scan_idx_reg >= IDX_W'(2)))
                begin
                    zero_found_next = 1'b1;
                    zero_idx_next   = scan_idx_reg;
                end
                // rotate so the next entry reaches the head; a full pass restores order
                for (int k = 0; k < NUM_SESSIONS - 1; k++)
                begin
                    table_next[k] = table_reg[k+1];
                end
                table_next[NUM_SESSIONS-1] = table_reg[0];
                if (scan_idx_reg == IDX_W'(NUM_SESSIONS - 1))
                begin
                    state_next = rsess_pkg::ST_UPDATE;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + IDX_W'(1);
                end
            end
            rsess_pkg::ST_UPDATE:
            begin
                if (do_move)
                begin
                    table_next[0] = new_entry;
                    for (int k = 1; k < NUM_SESSIONS; k++)
                    begin
                        if (IDX_W'(k) <= move_pos)
                        begin
                            table_next[k] = table_reg[k-1];
                        end
                    end
                end
                if (req_reg == rsess_pkg::REQ_ADD)
                begin
                    res_status_next = rsess_pkg::STATUS_OK;
                end
                else if (!match_found_reg)
                begin
                    res_status_next = rsess_pkg::STATUS_UNKNOWN;
                end
                else if (replay_reg)
                begin
                    res_status_next = rsess_pkg::STATUS_REPLAY;
                end
                else
                begin
                    res_status_next = rsess_pkg::STATUS_OK;
                end
                res_slot_next = rep_ext[rsess_pkg::SLOT_W-1:0];
                state_next    = rsess_pkg::ST_DELIVER;
            end
            rsess_pkg::ST_DELIVER:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {3'b000, res_slot_reg, res_status_reg};
                    state_next    = rsess_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rsess_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== tb/sv/replay_session_table_tb.sv =====
// self-checking testbench for the replay session table: predictor, driver and monitor
`timescale 1ns / 100ps

module replay_session_table_tb;

    localparam int NS          = rsess_pkg::NUM_SESSIONS_DEF;
    localparam int POOL        = 12;
    localparam int RAND_ITEMS  = 850;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        rsess_pkg::req_t  req;
        logic [63:0]      id_hi;
        logic [63:0]      id_lo;
        logic [31:0]      ctr;
        int unsigned      gap;
        bit               drain;
    } request_t;

    typedef struct packed {
        rsess_pkg::status_t  status;
        logic [2:0]          slot;
    } verdict_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    // session_id_high [63:0], session_id_low [127:64], nonce_counter [159:128]
    logic [rsess_pkg::IN_DATA_W-1:0]  s_tdata = '0;
    // req_type [0]
    logic                             s_tuser = 1'b0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    // status [1:0], slot_found [4:2], zeros [7:5]
    logic [rsess_pkg::OUT_DATA_W-1:0] m_tdata;

    // shadow copy of the session table, position 0 most recent
    logic [63:0] tbl_hi  [NS];
    logic [63:0] tbl_lo  [NS];
    logic [31:0] tbl_ctr [NS];

    request_t            request_q[$];
    verdict_t            verdict_q[$];
    request_t            next_req;
    verdict_t            got;
    rsess_pkg::status_t  exp_status;
    logic [2:0]          exp_slot;

    int unsigned idle_left = 0;
    int unsigned stall_left = 0;
    int unsigned cycle_cnt = 0;
    int unsigned err_cnt = 0;
    int unsigned n_added = 0;
    int unsigned n_accepted = 0;
    int unsigned n_replay = 0;
    int unsigned n_unknown = 0;

    replay_session_table uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 15);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic move_to_front(input int pos);
        logic [63:0] h;
        logic [63:0] l;
        logic [31:0] c;
        h = tbl_hi[pos];
        l = tbl_lo[pos];
        c = tbl_ctr[pos];
        for (int k = pos; k > 0; k--)
        begin
            tbl_hi[k]  = tbl_hi[k-1];
            tbl_lo[k]  = tbl_lo[k-1];
            tbl_ctr[k] = tbl_ctr[k-1];
        end
        tbl_hi[0]  = h;
        tbl_lo[0]  = l;
        tbl_ctr[0] = c;
    endtask

    // updates the shadow table and returns the verdict for one request
    task automatic session_lookup(input rsess_pkg::req_t req, input logic [63:0] hi,
                                  input logic [63:0] lo, input logic [31:0] ctr,
                                  output rsess_pkg::status_t st,
                                  output logic [2:0] slot);
        int pos;
        bit hit;
        st  = rsess_pkg::STATUS_UNKNOWN;
        pos = 0;
        hit = 1'b0;
        if (req == rsess_pkg::REQ_ADD)
        begin
            pos = -1;
            // empty means upper id word and counter both zero
            for (int k = 0; k < NS; k++)
                if (pos < 0 && tbl_hi[k][63:32] == 32'd0 && tbl_ctr[k] == 32'd0)
                    pos = k;
            // oldest zero-counter slot, sparing the two most recent
            for (int k = NS - 1; k > 1; k--)
                if (pos < 0 && tbl_ctr[k] == 32'd0)
                    pos = k;
            if (pos < 0)
            begin
                pos = NS - 1;
                tbl_ctr[pos] = 32'd0;
            end
            tbl_hi[pos] = hi;
            tbl_lo[pos] = lo;
            move_to_front(pos);
            st = rsess_pkg::STATUS_OK;
        end
        else
        begin
            for (int k = 0; k < NS; k++)
            begin
                if (!hit && tbl_hi[k] == hi && tbl_lo[k] == lo)
                begin
                    hit = 1'b1;
                    pos = k;
                    if (ctr <= tbl_ctr[k])
                        st = rsess_pkg::STATUS_REPLAY;
                    else
                    begin
                        tbl_ctr[k] = ctr;
                        move_to_front(k);
                        st = rsess_pkg::STATUS_OK;
                    end
                end
            end
        end
        slot = pos[2:0];
    endtask

    task automatic queue_beat(input rsess_pkg::req_t req, input logic [63:0] hi,
                              input logic [63:0] lo, input logic [31:0] ctr,
                              input bit drain);
        request_t b;
        b.req   = req;
        b.id_hi = hi;
        b.id_lo = lo;
        b.ctr   = ctr;
        b.drain = drain;
        // every fourth run of 60 beats goes back to back
        b.gap   = ((request_q.size() / 60) % 4 == 1) ? 0 : pick_gap();
        request_q.push_back(b);
    endtask

    // driver: predicts on acceptance, then presents the next pending beat
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid  <= 1'b0;
            s_tdata   <= '0;
            s_tuser   <= 1'b0;
            idle_left <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                session_lookup(rsess_pkg::req_t'(s_tuser), s_tdata[63:0], s_tdata[127:64],
                               s_tdata[159:128], exp_status, exp_slot);
                verdict_q.push_back('{exp_status, exp_slot});
            end
            if (!s_tvalid || s_tready)
            begin
                if (idle_left > 0)
                begin
                    idle_left <= idle_left - 1;
                    s_tvalid  <= 1'b0;
                end
                else if (request_q.size() == 0 ||
                         (request_q[0].drain && verdict_q.size() != 0))
                    s_tvalid <= 1'b0;
                else
                begin
                    next_req  = request_q.pop_front();
                    s_tdata   <= {next_req.ctr, next_req.id_lo, next_req.id_hi};
                    s_tuser   <= next_req.req;
                    s_tvalid  <= 1'b1;
                    idle_left <= next_req.gap;
                end
            end
        end
    end

    // monitor: checks each result beat and stalls the output at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (verdict_q.size() == 0)
                begin
                    if (err_cnt < 10)
                        $display("[%0d] result beat with nothing pending: status %0d slot %0d",
                                 cycle_cnt, m_tdata[1:0], m_tdata[4:2]);
                    err_cnt++;
                end
                else
                begin
                    got = verdict_q.pop_front();
                    case (got.status)
                        rsess_pkg::STATUS_OK:     n_accepted++;
                        rsess_pkg::STATUS_REPLAY: n_replay++;
                        default:                  n_unknown++;
                    endcase
                    if (m_tdata[1:0] != got.status || m_tdata[4:2] != got.slot)
                    begin
                        if (err_cnt < 10)
                            $display("[%0d] mismatch: status exp %0d got %0d, slot exp %0d got %0d",
                                     cycle_cnt, got.status, m_tdata[1:0], got.slot,
                                     m_tdata[4:2]);
                        err_cnt++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                m_tready   <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                // quiet window with no stalls now and then
                if (cycle_cnt[11:10] != 2'b01 && $urandom_range(0, 99) < 25)
                    stall_left <= pick_gap() + 1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        logic [63:0] pool_hi  [POOL];
        logic [63:0] pool_lo  [POOL];
        logic [31:0] pool_ctr [POOL];
        logic [63:0] dir_hi   [10];
        logic [63:0] dir_lo   [10];
        logic [31:0] c;
        int unsigned r;
        int unsigned idx;
        int unsigned settle;
        bit drain;

        for (int k = 0; k < NS; k++)
        begin
            tbl_hi[k]  = '0;
            tbl_lo[k]  = '0;
            tbl_ctr[k] = '0;
        end

        dir_hi[0] = 64'h0123_4567_89AB_CDEF;
        dir_lo[0] = 64'hFEDC_BA98_7654_3210;
        dir_hi[1] = '1;
        dir_lo[1] = '1;
        dir_hi[2] = 64'h0000_0000_DEAD_BEEF;
        dir_lo[2] = 64'h1;
        for (int k = 3; k < 10; k++)
        begin
            dir_hi[k] = rand64();
            dir_lo[k] = rand64();
        end

        // zero id against a cleared table, replay, unknown, counter extremes
        queue_beat(rsess_pkg::REQ_VERIFY, '0, '0, 32'd0, 1'b0);
        queue_beat(rsess_pkg::REQ_VERIFY, '0, '0, 32'd5, 1'b0);
        queue_beat(rsess_pkg::REQ_VERIFY, dir_hi[0], dir_lo[0], 32'd1, 1'b0);
        queue_beat(rsess_pkg::REQ_ADD, dir_hi[0], dir_lo[0], 32'hFFFF_FFFF, 1'b0);
        queue_beat(rsess_pkg::REQ_VERIFY, dir_hi[0], dir_lo[0], 32'hFFFF_FFFF, 1'b0);
        queue_beat(rsess_pkg::REQ_VERIFY, dir_hi[0], dir_lo[0], 32'hFFFF_FFFF, 1'b0);
        queue_beat(rsess_pkg::REQ_VERIFY, dir_hi[0], dir_lo[0], 32'd0, 1'b0);
        // duplicate add, then a verify that has two matching entries
        queue_beat(rsess_pkg::REQ_ADD, dir_hi[0], dir_lo[0], 32'd0, 1'b0);
        queue_beat(rsess_pkg::REQ_VERIFY, dir_hi[0], dir_lo[0], 32'd1, 1'b0);
        // fill the table, then force the zero-counter and oldest-slot choices
        for (int k = 1; k < 5; k++)
            queue_beat(rsess_pkg::REQ_ADD, dir_hi[k], dir_lo[k], $urandom(), 1'b0);
        queue_beat(rsess_pkg::REQ_VERIFY, dir_hi[1], dir_lo[1], 32'd3, 1'b0);
        queue_beat(rsess_pkg::REQ_VERIFY, dir_hi[2], dir_lo[2], 32'd9, 1'b0);
        queue_beat(rsess_pkg::REQ_VERIFY, dir_hi[3], dir_lo[3], 32'd2, 1'b0);
        for (int k = 5; k < 8; k++)
            queue_beat(rsess_pkg::REQ_ADD, dir_hi[k], dir_lo[k], $urandom(), 1'b0);
        for (int k = 5; k < 8; k++)
            queue_beat(rsess_pkg::REQ_VERIFY, dir_hi[k], dir_lo[k], 32'd1, 1'b0);
        queue_beat(rsess_pkg::REQ_VERIFY, dir_hi[4], dir_lo[4], 32'd7, 1'b0);
        queue_beat(rsess_pkg::REQ_ADD, dir_hi[8], dir_lo[8], 32'd0, 1'b0);
        queue_beat(rsess_pkg::REQ_VERIFY, dir_hi[8], dir_lo[8], 32'd1, 1'b0);
        queue_beat(rsess_pkg::REQ_ADD, dir_hi[9], dir_lo[9], 32'd0, 1'b0);

        for (int k = 0; k < POOL; k++)
        begin
            pool_hi[k]  = rand64();
            pool_lo[k]  = rand64();
            pool_ctr[k] = 32'd0;
        end
        pool_hi[0] = '0;
        pool_lo[0] = '0;
        pool_hi[1] = '1;
        pool_lo[1] = '1;
        pool_hi[2][63:32] = 32'd0;
        pool_hi[3][63:32] = 32'd0;

        // mostly add-then-verify traffic on a small id pool, some noise
        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            idx   = $urandom_range(0, POOL - 1);
            r     = $urandom_range(0, 99);
            drain = (i == 0 || i == 300 || i == 600);
            if (r < 2 && idx > 1)
            begin
                pool_hi[idx] = rand64();
                if ($urandom_range(0, 1) == 1)
                    pool_hi[idx][63:32] = 32'd0;
                pool_lo[idx]  = rand64();
                pool_ctr[idx] = 32'd0;
            end
            if (r < 20)
            begin
                queue_beat(rsess_pkg::REQ_ADD, pool_hi[idx], pool_lo[idx], $urandom(), drain);
                pool_ctr[idx] = 32'd0;
            end
            else if (r < 75)
            begin
                if ($urandom_range(0, 9) == 0)
                    c = $urandom();
                else
                    c = pool_ctr[idx] + $urandom_range(1, 1000);
                queue_beat(rsess_pkg::REQ_VERIFY, pool_hi[idx], pool_lo[idx], c, drain);
                if (c > pool_ctr[idx])
                    pool_ctr[idx] = c;
            end
            else if (r < 87)
            begin
                c = pool_ctr[idx] - $urandom_range(0, (pool_ctr[idx] < 40) ? pool_ctr[idx] : 40);
                queue_beat(rsess_pkg::REQ_VERIFY, pool_hi[idx], pool_lo[idx], c, drain);
            end
            else if (r < 95)
                queue_beat(rsess_pkg::REQ_VERIFY, rand64(), rand64(), $urandom(), drain);
            else
                queue_beat(rsess_pkg::REQ_ADD, rand64(), rand64(), $urandom(), drain);
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (request_q.size() != 0 || s_tvalid)
            @(posedge clk);
        settle = 0;
        while (verdict_q.size() != 0 && settle < 20000)
        begin
            @(posedge clk);
            settle++;
        end
        repeat (NS + 8) @(posedge clk);

        if (verdict_q.size() != 0)
        begin
            $display("%0d expected results never arrived", verdict_q.size());
            err_cnt++;
        end

        $display("covered %0d requests: %0d accepted or added, %0d replays, %0d unknown",
                 n_accepted + n_replay + n_unknown, n_accepted, n_replay, n_unknown);
        $display("errors: %0d", err_cnt);
        if (err_cnt == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
